[rtl/esst_pkg.sv]
`default_nettype none

package esst_pkg;

  // Fixed field widths.
  localparam int unsigned X_W = 20;
  localparam int unsigned RES_W = 32;

  // Internal datapath widths.
  localparam int unsigned R_W = 36;     // |x| in Q32, up to 8.0
  localparam int unsigned H_W = 48;     // Horner and squaring value, Q32
  localparam int unsigned K_W = 3;      // halving count, at most six
  localparam int unsigned N_W = 31;     // Horner dividend
  localparam int unsigned Q_W = 21;     // reciprocal quotient bits
  localparam int unsigned MUL_W = 32;   // shared multiplier operand width

  // Default number of series terms.
  localparam int unsigned TAYLOR_TERMS_DEF = 10;

  // Q32 constants.
  localparam logic [H_W-1:0] ONE_Q32 = H_W'(64'h1_0000_0000);
  localparam logic [R_W-1:0] EIGHTH_Q32 = R_W'(64'h2000_0000);
  localparam logic [H_W-1:0] RECIP_BIAS = H_W'(64'h8000_0000);

  // Sequencing counts.
  localparam int unsigned LMUL_LAST = 4;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned STEP_W = 3;

  // Reciprocals floor((2^32 - 1) / i) for the Horner divisors.
  localparam int unsigned RECIP_DEPTH = 32;
  localparam int unsigned RECIP_IDX_W = $clog2(RECIP_DEPTH);
  localparam logic [MUL_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
    32'd0,
    32'hFFFF_FFFF / 32'd1,  32'hFFFF_FFFF / 32'd2,  32'hFFFF_FFFF / 32'd3,
    32'hFFFF_FFFF / 32'd4,  32'hFFFF_FFFF / 32'd5,  32'hFFFF_FFFF / 32'd6,
    32'hFFFF_FFFF / 32'd7,  32'hFFFF_FFFF / 32'd8,  32'hFFFF_FFFF / 32'd9,
    32'hFFFF_FFFF / 32'd10, 32'hFFFF_FFFF / 32'd11, 32'hFFFF_FFFF / 32'd12,
    32'hFFFF_FFFF / 32'd13, 32'hFFFF_FFFF / 32'd14, 32'hFFFF_FFFF / 32'd15,
    32'hFFFF_FFFF / 32'd16,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SHIFT,
    OP_MUL_RH,
    OP_MUL_HH,
    OP_HN,
    OP_HQEST,
    OP_HQI,
    OP_HCORR,
    OP_HUPD,
    OP_SQUPD,
    OP_DINIT,
    OP_DSTEP,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic r_big;
    logic i_one;
    logic k_zero;
    logic neg;
  } sts_t;

endpackage

`default_nettype wire

[rtl/esst_mul.sv]
`default_nettype none

module esst_mul
  import esst_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [MUL_W-1:0]     a,
  input  wire logic [MUL_W-1:0]     b,
  output logic      [2*MUL_W-1:0]   prod
);

  // Unsigned product, registered before any use.
  always_ff @(posedge clk) begin
    prod <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
  end

endmodule

`default_nettype wire

[rtl/esst_dpath.sv]
`default_nettype none

module esst_dpath
  import esst_pkg::*;
#(
  parameter int unsigned TAYLOR_TERMS = TAYLOR_TERMS_DEF
)
(
  input  wire logic                  clk,
  input  wire cmd_t                  cmd,
  input  wire logic signed [X_W-1:0] x_value,
  output sts_t                       sts,
  output logic [RES_W-1:0]           exp_result
);

  localparam int unsigned I_W = $clog2(TAYLOR_TERMS + 1);

  logic             neg;
  logic [R_W-1:0]   r;
  logic [K_W-1:0]   k;
  logic [H_W-1:0]   h;
  logic [I_W-1:0]   i;
  logic [H_W-1:0]   acc;
  logic [N_W-1:0]   nreg;
  logic [N_W-1:0]   qreg;
  logic             corr;
  logic [H_W-1:0]   rem;
  logic [Q_W-1:0]   dlow;
  logic [Q_W-1:0]   quo;

  logic [MUL_W-1:0]   ma;
  logic [MUL_W-1:0]   mb;
  logic [2*MUL_W-1:0] mprod;

  logic [H_W-1:0]   opa;
  logic [X_W-1:0]   mag;
  logic [MUL_W+1:0] round_lo;
  logic [MUL_W:0]   qi_plus;
  logic [H_W:0]     rem2;
  logic [RES_W+4:0] pos_res;
  logic [RES_W-1:0] pos_sat;

  // Shared multiplier.
  esst_mul u_mul (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (mprod)
  );

  // Magnitude of the argument; the most negative code maps to 8.0.
  assign mag = x_value[X_W-1] ? (~x_value + X_W'(1)) : x_value;

  // First operand of the long multiply.
  assign opa = (cmd.op == OP_MUL_RH) ? H_W'(r) : h;

  // Multiplier operand selection for the current step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_RH, OP_MUL_HH: begin
        case (cmd.step)
          3'd0: begin
            ma = opa[MUL_W-1:0];
            mb = h[MUL_W-1:0];
          end
          3'd1: begin
            ma = MUL_W'(opa[H_W-1:MUL_W]);
            mb = h[MUL_W-1:0];
          end
          3'd2: begin
            ma = opa[MUL_W-1:0];
            mb = MUL_W'(h[H_W-1:MUL_W]);
          end
          3'd3: begin
            ma = MUL_W'(opa[H_W-1:MUL_W]);
            mb = MUL_W'(h[H_W-1:MUL_W]);
          end
          default: begin
            ma = '0;
            mb = '0;
          end
        endcase
      end
      OP_HQEST: begin
        ma = MUL_W'(nreg);
        mb = RECIP_TABLE[RECIP_IDX_W'(i)];
      end
      OP_HQI: begin
        ma = mprod[2*MUL_W-1:MUL_W];
        mb = MUL_W'(i);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Rounded upper half of the low partial product.
  assign round_lo = (MUL_W+2)'(mprod[2*MUL_W-1:MUL_W-1]) + (MUL_W+2)'(1);

  // Quotient estimate times divisor, plus divisor, for the correction test.
  assign qi_plus = (MUL_W+1)'(mprod[MUL_W-1:0]) + (MUL_W+1)'(i);

  // One restoring division step.
  assign rem2 = {rem, dlow[Q_W-1]};

  // Positive result: round Q32 to Q20 and saturate.
  assign pos_res = (RES_W+5)'(h[H_W-1:12]) + (RES_W+5)'(h[11]);
  assign pos_sat = (pos_res[RES_W+4:RES_W] != '0) ? '1 : pos_res[RES_W-1:0];

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        neg <= x_value[X_W-1];
        r   <= {mag, 16'd0};
        k   <= '0;
        h   <= ONE_Q32;
        i   <= I_W'(TAYLOR_TERMS);
      end
      OP_SHIFT: begin
        r <= r >> 1;
        k <= k + K_W'(1);
      end
      OP_MUL_RH, OP_MUL_HH: begin
        case (cmd.step)
          3'd1: acc <= H_W'(round_lo[MUL_W+1:1]);
          3'd2: acc <= acc + mprod[H_W-1:0];
          3'd3: acc <= acc + mprod[H_W-1:0];
          3'd4: acc <= acc + {mprod[H_W-MUL_W-1:0], {MUL_W{1'b0}}};
          default: acc <= acc;
        endcase
      end
      OP_HN: begin
        nreg <= acc[N_W-1:0] + N_W'(i >> 1);
      end
      OP_HQI: begin
        qreg <= mprod[MUL_W+N_W-1:MUL_W];
      end
      OP_HCORR: begin
        corr <= ((MUL_W+1)'(nreg) >= qi_plus);
      end
      OP_HUPD: begin
        h <= ONE_Q32 + H_W'(qreg) + H_W'(corr);
        i <= i - I_W'(1);
      end
      OP_SQUPD: begin
        h <= acc;
        k <= k - K_W'(1);
      end
      OP_DINIT: begin
        rem  <= RECIP_BIAS + H_W'(h[H_W-1:Q_W+1]);
        dlow <= h[Q_W:1];
        quo  <= '0;
      end
      OP_DSTEP: begin
        dlow <= dlow << 1;
        if (rem2 >= {1'b0, h}) begin
          rem <= H_W'(rem2 - {1'b0, h});
          quo <= {quo[Q_W-2:0], 1'b1};
        end else begin
          rem <= rem2[H_W-1:0];
          quo <= {quo[Q_W-2:0], 1'b0};
        end
      end
      OP_RESULT: begin
        exp_result <= neg ? RES_W'(quo) : pos_sat;
      end
      default: begin
        neg <= neg;
      end
    endcase
  end

  // Status to the controller.
  assign sts.r_big  = (r > EIGHTH_Q32);
  assign sts.i_one  = (i == I_W'(1));
  assign sts.k_zero = (k == '0);
  assign sts.neg    = neg;

endmodule

`default_nettype wire

[rtl/esst_ctrl.sv]
`default_nettype none

module esst_ctrl
  import esst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_LMUL,
    S_HN,
    S_HQEST,
    S_HQI,
    S_HCORR,
    S_HUPD,
    S_SQCHK,
    S_SQUPD,
    S_DINIT,
    S_DSTEP,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             sq_phase;
  logic             out_free;

  // The output register is free when empty or being emptied.
  assign out_free = !out_valid || !out_stall;

  // No request is taken while in reset or while one is being worked on.
  assign in_stall = rst || (state != S_IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.step = cnt[STEP_W-1:0];
    case (state)
      S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_REDUCE: cmd.op = sts.r_big ? OP_SHIFT : OP_NONE;
      S_LMUL:   cmd.op = sq_phase ? OP_MUL_HH : OP_MUL_RH;
      S_HN:     cmd.op = OP_HN;
      S_HQEST:  cmd.op = OP_HQEST;
      S_HQI:    cmd.op = OP_HQI;
      S_HCORR:  cmd.op = OP_HCORR;
      S_HUPD:   cmd.op = OP_HUPD;
      S_SQUPD:  cmd.op = OP_SQUPD;
      S_DINIT:  cmd.op = OP_DINIT;
      S_DSTEP:  cmd.op = OP_DSTEP;
      S_DONE:   cmd.op = out_free ? OP_RESULT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // Sequencer state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sq_phase  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A taken result empties the output register unless a new one lands.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_REDUCE;
            sq_phase <= 1'b0;
            cnt      <= '0;
          end
        end
        S_REDUCE: begin
          if (!sts.r_big) begin
            state <= S_LMUL;
          end
        end
        S_LMUL: begin
          if (cnt == CNT_W'(LMUL_LAST)) begin
            cnt   <= '0;
            state <= sq_phase ? S_SQUPD : S_HN;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_HN:    state <= S_HQEST;
        S_HQEST: state <= S_HQI;
        S_HQI:   state <= S_HCORR;
        S_HCORR: state <= S_HUPD;
        S_HUPD: begin
          if (sts.i_one) begin
            state    <= S_SQCHK;
            sq_phase <= 1'b1;
          end else begin
            state <= S_LMUL;
          end
        end
        S_SQCHK: begin
          if (sts.k_zero) begin
            state <= sts.neg ? S_DINIT : S_DONE;
          end else begin
            state <= S_LMUL;
          end
        end
        S_SQUPD: state <= S_SQCHK;
        S_DINIT: begin
          state <= S_DSTEP;
          cnt   <= '0;
        end
        S_DSTEP: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/exp_scale_square_taylor_top.sv]
// Computes e^x for a signed Q4.16 request on x_value and returns an unsigned
// Q12.20 exp_result by scaling and squaring: |x| is halved until it is at most
// 1/8, a Taylor series of TAYLOR_TERMS terms is evaluated in Horner form, the
// result is squared once per halving, and for a negative argument the
// reciprocal is taken by a restoring divider producing one quotient bit per
// cycle. One request is worked on at a time. Every multiply goes through the
// single 32x32 multiplier: each wide Q32 product is built from four partial
// products, and each Horner division is a multiply by a reciprocal plus a
// correction. A finished result waits in the output register while the next
// request is taken.
`default_nettype none

module exp_scale_square_taylor_top
  import esst_pkg::*;
#(
  parameter int unsigned TAYLOR_TERMS = TAYLOR_TERMS_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [X_W-1:0] x_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [RES_W-1:0]           exp_result
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  esst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  esst_dpath #(
    .TAYLOR_TERMS (TAYLOR_TERMS)
  ) u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .x_value    (x_value),
    .sts        (sts),
    .exp_result (exp_result)
  );

endmodule

`default_nettype wire
